@@ design/ctvd_pkg.sv @@
package ctvd_pkg;

  localparam int unsigned FrameLen = 11;
  localparam int unsigned FillW = $clog2(FrameLen + 1);
  localparam int unsigned CntW = 32;
  localparam int unsigned OutCntW = 32;
  localparam int unsigned ValW = 24;
  localparam logic [7:0] MarkerReset = 8'h5a;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);
  localparam int unsigned QCntW = $clog2(QDepth + 1);

  typedef struct packed {
    logic signed [ValW-1:0] first_value;
    logic signed [ValW-1:0] second_value;
    logic signed [ValW-1:0] third_value;
    logic [OutCntW-1:0]     bytes_seen;
    logic [OutCntW-1:0]     frames_seen;
  } result_t;

endpackage

@@ design/ctvd_front.sv @@
module ctvd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              cfg_valid_i,
  input  logic [7:0]        cfg_data_i,
  output logic              res_valid_o,
  output ctvd_pkg::result_t res_o
);
  import ctvd_pkg::*;

  logic [7:0]       win_q [FrameLen];
  logic [7:0]       win_d [FrameLen];
  logic [FillW-1:0] fill_q, fill_d;
  logic [7:0]       sum_q, sum_d, sum_win;
  logic [CntW-1:0]  byte_cnt_q, byte_cnt_d;
  logic [CntW-1:0]  frame_cnt_q, frame_cnt_d;
  logic [7:0]       marker_q;
  logic             frame_ok;

  always_comb begin
    win_d       = win_q;
    fill_d      = fill_q;
    sum_win     = sum_q;
    byte_cnt_d  = byte_cnt_q;
    frame_cnt_d = frame_cnt_q;
    frame_ok    = 1'b0;
    if (accept_i) begin
      if (fill_q < FillW'(FrameLen)) begin
        win_d[fill_q] = rx_byte_i;
        fill_d        = fill_q + FillW'(1);
        if (fill_q < FillW'(FrameLen - 1)) begin
          sum_win = sum_q + rx_byte_i;
        end
      end else begin
        for (int k = 0; k < FrameLen - 1; k++) begin
          win_d[k] = win_q[k+1];
        end
        win_d[FrameLen-1] = rx_byte_i;
        sum_win = sum_q - win_q[0] + win_q[FrameLen-1];
      end
      byte_cnt_d = byte_cnt_q + CntW'(1);
      frame_ok   = (fill_d == FillW'(FrameLen)) && (win_d[0] == marker_q)
                   && (sum_win == rx_byte_i);
      if (frame_ok) begin
        frame_cnt_d = frame_cnt_q + CntW'(1);
        fill_d      = '0;
      end
    end
    sum_d = frame_ok ? 8'd0 : sum_win;
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      sum_q       <= '0;
      byte_cnt_q  <= '0;
      frame_cnt_q <= '0;
      marker_q    <= MarkerReset;
    end else begin
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      byte_cnt_q  <= byte_cnt_d;
      frame_cnt_q <= frame_cnt_d;
      if (cfg_valid_i) begin
        marker_q <= cfg_data_i;
      end
    end
  end

  assign res_valid_o       = frame_ok;
  assign res_o.first_value  = {win_d[3], win_d[2], win_d[1]};
  assign res_o.second_value = {win_d[6], win_d[5], win_d[4]};
  assign res_o.third_value  = {win_d[9], win_d[8], win_d[7]};
  assign res_o.bytes_seen   = OutCntW'(byte_cnt_d);
  assign res_o.frames_seen  = OutCntW'(frame_cnt_d);

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(FrameLen))
    else $error("window fill level out of range");
  a_frame_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (fill_q == '0) && (sum_q == 8'd0))
    else $error("window not emptied after a frame");
  a_frame_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_o |=> $stable(frame_cnt_q))
    else $error("frame counter moved without a frame");
`endif

endmodule

@@ design/ctvd_fifo.sv @@
module ctvd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ctvd_pkg::result_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output ctvd_pkg::result_t data_o
);
  import ctvd_pkg::*;

  result_t          mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("result dropped into a full queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count out of range");
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full_o && empty_o))
    else $error("queue reports full and empty together");
`endif

endmodule

@@ design/checksummed_triple_value_deframer_top.sv @@
// Channel   Handshake                 Payload
// input     push / full               rx_byte_i
// config    cfg_valid_i / cfg_ready_o cfg_data_i (start marker)
// result    empty / pop               first_value_o .. frames_seen_o
//
// One byte is taken every cycle while full is low; a frame check completes in the
// cycle of its last byte, and its result is registered into the result queue.
// A four-entry result queue separates the window logic from the consumer.
// full rises only when that queue holds four results that have not been popped.
// Reset is asynchronous and active low and empties the window, counters and queue.
module checksummed_triple_value_deframer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [7:0]                     cfg_data_i,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [ctvd_pkg::ValW-1:0] first_value_o,
  output logic signed [ctvd_pkg::ValW-1:0] second_value_o,
  output logic signed [ctvd_pkg::ValW-1:0] third_value_o,
  output logic [ctvd_pkg::OutCntW-1:0]   bytes_seen_o,
  output logic [ctvd_pkg::OutCntW-1:0]   frames_seen_o
);
  import ctvd_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t q_data;

  assign accept      = push && !full;
  assign cfg_ready_o = 1'b1;

  ctvd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (rx_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ctvd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (q_data)
  );

  assign first_value_o  = q_data.first_value;
  assign second_value_o = q_data.second_value;
  assign third_value_o  = q_data.third_value;
  assign bytes_seen_o   = q_data.bytes_seen;
  assign frames_seen_o  = q_data.frames_seen;

endmodule
